/* src/snrl_pkg.sv */
`default_nettype none
package snrl_pkg;

  typedef logic [1:0] opcode_t;
  typedef logic [1:0] cfg_index_t;

  localparam opcode_t OP_LOAD    = 2'd0;
  localparam opcode_t OP_COMPUTE = 2'd1;
  localparam opcode_t OP_LEARN   = 2'd2;

  localparam cfg_index_t CFG_THRESHOLD = 2'd0;
  localparam cfg_index_t CFG_DISCOUNT  = 2'd1;
  localparam cfg_index_t CFG_RATE      = 2'd2;

  localparam logic signed [19:0] THRESHOLD_RST = 20'sd256;
  localparam logic [15:0]        DISCOUNT_RST  = 16'd58982;
  localparam logic [15:0]        RATE_RST      = 16'd655;

  localparam int DIV_NW = 32;
  localparam int DIV_DW = 16;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

/* src/snrl_if.sv */
`default_nettype none
interface snrl_item_if;
  import snrl_pkg::*;
  logic               valid;
  logic               ready;
  opcode_t            opcode;
  logic [5:0]         neuron_index;
  logic [3:0]         synapse_index;
  logic signed [15:0] weight_value;
  logic [15:0]        spike_bits;
  logic signed [15:0] reward;
  modport source (output valid, opcode, neuron_index, synapse_index, weight_value,
                  spike_bits, reward, input ready);
  modport sink (input valid, opcode, neuron_index, synapse_index, weight_value,
                spike_bits, reward, output ready);
endinterface

interface snrl_res_if;
  logic               valid;
  logic               ready;
  logic               fired;
  logic signed [19:0] act_sum;
  logic               saturated;
  modport source (output valid, fired, act_sum, saturated, input ready);
  modport sink (input valid, fired, act_sum, saturated, output ready);
endinterface

interface snrl_cfg_if;
  import snrl_pkg::*;
  logic        valid;
  logic        ready;
  cfg_index_t  index;
  logic [19:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* src/snrl_ram.sv */
`default_nettype none
module snrl_ram #(
  parameter int W = 16,
  parameter int D = 1024,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [W-1:0]  wdata_i,
  output logic      [W-1:0]  rdata_o
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

/* src/snrl_div.sv */
`default_nettype none
module snrl_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [snrl_pkg::DIV_NW-1:0]   dividend_i,
  input  wire logic [snrl_pkg::DIV_DW-1:0]   divisor_i,
  output snrl_pkg::div_stat_t                stat_o,
  output logic      [snrl_pkg::DIV_NW-1:0]   quot_o
);
  import snrl_pkg::*;

  localparam int CW = $clog2(DIV_NW + 1);

  logic [DIV_DW:0]   rem_q, rem_d, rem_sh;
  logic [DIV_NW-1:0] quot_q, quot_d;
  logic [DIV_DW-1:0] dsr_q, dsr_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;

  // restoring divide, one quotient bit a cycle
  assign rem_sh = {rem_q[DIV_DW-1:0], quot_q[DIV_NW-1]};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quot_d = dividend_i;
      dsr_d  = divisor_i;
      cnt_d  = CW'(DIV_NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, dsr_q}) begin
        rem_d  = rem_sh - {1'b0, dsr_q};
        quot_d = {quot_q[DIV_NW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        quot_d = {quot_q[DIV_NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dsr_q  <= dsr_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quot_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |-> !busy_q)
    else $error("divider started while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("divider done while still busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (busy_q && !start_i && cnt_q == CW'(1)) |=> done_q)
    else $error("divider missed its done pulse");
endmodule
`default_nettype wire

/* src/spiking_neuron_reward_learning.sv */
// steps: load writes one synapse, then finishes; an out-of-range neuron or unused
// opcode goes straight to finish; compute decays and sums each synapse, and
// makes a second pass if it fires; learn uses the bit-serial divider per synapse.
// one item at a time; a finished result may wait in the output register.
// after reset a clearing pass writes zero to every entry of both memories,
// with no item accepted; config writes are always taken.
`default_nettype none
module spiking_neuron_reward_learning #(
  parameter int NEURONS  = 64,
  parameter int SYNAPSES = 16
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  snrl_item_if.sink   item_i,
  snrl_res_if.source  result_o,
  snrl_cfg_if.sink    cfg_i
);
  import snrl_pkg::*;

  localparam int DEPTH = NEURONS * SYNAPSES;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW    = (SYNAPSES > 1) ? $clog2(SYNAPSES) : 1;
  localparam int SUMW  = 17 + KW;

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_LOAD   = 4'd2;
  localparam logic [3:0] S_RD     = 4'd3;
  localparam logic [3:0] S_EX     = 4'd4;
  localparam logic [3:0] S_WR     = 4'd5;
  localparam logic [3:0] S_DECIDE = 4'd6;
  localparam logic [3:0] S_FRD    = 4'd7;
  localparam logic [3:0] S_FEX    = 4'd8;
  localparam logic [3:0] S_LRD    = 4'd9;
  localparam logic [3:0] S_LEX    = 4'd10;
  localparam logic [3:0] S_LMUL   = 4'd11;
  localparam logic [3:0] S_LDS    = 4'd12;
  localparam logic [3:0] S_LDIV   = 4'd13;
  localparam logic [3:0] S_LWR    = 4'd14;
  localparam logic [3:0] S_FIN    = 4'd15;

  logic [3:0] state_q, state_d;

  // config registers
  logic signed [19:0] thr_q;
  logic [15:0]        disc_q, rate_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= THRESHOLD_RST;
      disc_q <= DISCOUNT_RST;
      rate_q <= RATE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_THRESHOLD: thr_q  <= cfg_i.data;
        CFG_DISCOUNT:  disc_q <= cfg_i.data[15:0];
        CFG_RATE:      rate_q <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // item registers
  logic [AW-1:0]      base_q, base_d;
  logic [3:0]         syn_q, syn_d;
  logic signed [15:0] wv_q, wv_d, rew_q, rew_d;
  logic [15:0]        spk_q, spk_d;
  logic [KW-1:0]      k_q, k_d;
  logic [AW-1:0]      clr_q, clr_d;

  // datapath registers
  logic signed [SUMW-1:0] sum_q, sum_d;
  logic signed [32:0]     prod_q, prod_d;
  logic signed [47:0]     prod2_q, prod2_d;
  logic signed [15:0]     w_q, w_d;
  logic                   fired_q, fired_d, sat_q, sat_d;
  logic signed [19:0]     wsum_q, wsum_d;

  // output register
  logic               ov_q, ov_d;
  logic               o_fired_q, o_sat_q;
  logic signed [19:0] o_wsum_q;
  logic               o_load;

  // memories
  logic          w_we, t_we;
  logic [AW-1:0] ram_addr;
  logic [15:0]   w_wdata, t_wdata, w_rdata, t_rdata;

  snrl_ram #(.W(16), .D(DEPTH)) u_weight_ram (
    .clk_i, .we_i(w_we), .addr_i(ram_addr), .wdata_i(w_wdata), .rdata_o(w_rdata)
  );
  snrl_ram #(.W(16), .D(DEPTH)) u_trace_ram (
    .clk_i, .we_i(t_we), .addr_i(ram_addr), .wdata_i(t_wdata), .rdata_o(t_rdata)
  );

  // divider
  logic        div_start;
  div_stat_t   div_stat;
  logic [31:0] div_quot, div_num;
  logic [15:0] div_den;
  logic        neg_q, neg_d;
  logic [47:0] mag48;

  snrl_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_num),
    .divisor_i(div_den), .stat_o(div_stat), .quot_o(div_quot)
  );

  // combinational helpers
  logic               item_acc, spike, last_k, n_ok;
  logic [6:0]         kx;
  logic signed [15:0] rw_s, rt_s;
  logic signed [31:0] sum_x, sum_c;
  logic signed [33:0] dec_adj;
  logic signed [17:0] tinc;
  logic signed [33:0] dq;
  logic signed [34:0] nw;
  logic [15:0]        wabs;

  assign item_acc     = item_i.valid && item_i.ready;
  assign item_i.ready = (state_q == S_IDLE);
  assign n_ok         = 32'(item_i.neuron_index) < NEURONS;
  assign kx           = 7'(k_q);
  assign spike        = (kx < 7'd16) && spk_q[kx[3:0]];
  assign last_k       = (k_q == KW'(SYNAPSES - 1));
  assign rw_s         = w_rdata;
  assign rt_s         = t_rdata;
  assign sum_x        = 32'(sum_q);
  assign sum_c        = (sum_x > 32'sd524287) ? 32'sd524287 :
                        (sum_x < -32'sd524288) ? -32'sd524288 : sum_x;
  // truncate toward zero
  assign dec_adj      = 34'(prod_q) + ((prod_q < 0) ? 34'sd65535 : 34'sd0);
  assign tinc         = 18'(rt_s) + ((rw_s > 0) ? 18'sd256 :
                                     (rw_s < 0) ? -18'sd256 : 18'sd0);
  assign mag48        = (prod2_q < 0) ? 48'(-prod2_q) : 48'(prod2_q);
  assign div_num      = mag48[47:16];
  assign wabs         = (w_q < 0) ? 16'(-w_q) : 16'(w_q);
  assign div_den      = (w_q == 16'sd0) ? 16'd1 : wabs;
  assign dq           = neg_q ? -$signed({2'b00, div_quot}) : $signed({2'b00, div_quot});
  assign nw           = 35'(w_q) + 35'(dq);
  assign div_start    = (state_q == S_LDS);
  assign o_load       = (state_q == S_FIN) && (!ov_q || result_o.ready);

  always_comb begin
    state_d = state_q;
    base_d  = base_q;
    syn_d   = syn_q;
    wv_d    = wv_q;
    rew_d   = rew_q;
    spk_d   = spk_q;
    k_d     = k_q;
    clr_d   = clr_q;
    sum_d   = sum_q;
    prod_d  = prod_q;
    prod2_d = prod2_q;
    w_d     = w_q;
    neg_d   = neg_q;
    fired_d = fired_q;
    sat_d   = sat_q;
    wsum_d  = wsum_q;
    w_we    = 1'b0;
    t_we    = 1'b0;
    w_wdata = '0;
    t_wdata = '0;
    ram_addr = base_q + AW'(k_q);
    unique case (state_q)
      S_CLEAR: begin
        ram_addr = clr_q;
        w_we     = 1'b1;
        t_we     = 1'b1;
        clr_d    = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (item_acc) begin
          base_d  = AW'(32'(item_i.neuron_index) * SYNAPSES);
          syn_d   = item_i.synapse_index;
          wv_d    = item_i.weight_value;
          rew_d   = item_i.reward;
          spk_d   = item_i.spike_bits;
          k_d     = '0;
          sum_d   = '0;
          fired_d = 1'b0;
          sat_d   = 1'b0;
          wsum_d  = '0;
          state_d = S_FIN;
          if (n_ok) begin
            case (item_i.opcode)
              OP_LOAD:    state_d = S_LOAD;
              OP_COMPUTE: state_d = S_RD;
              OP_LEARN:   state_d = S_LRD;
              default:    state_d = S_FIN;
            endcase
          end
        end
      end
      S_LOAD: begin
        ram_addr = base_q + AW'(syn_q);
        if (32'(syn_q) < SYNAPSES) begin
          w_we    = 1'b1;
          t_we    = 1'b1;
          w_wdata = wv_q;
        end
        state_d = S_FIN;
      end
      S_RD: state_d = S_EX;
      S_EX: begin
        prod_d = 33'(rt_s) * 33'($signed({1'b0, disc_q}));
        if (spike) begin
          sum_d = sum_q + SUMW'(rw_s);
        end
        state_d = S_WR;
      end
      S_WR: begin
        t_we    = 1'b1;
        t_wdata = dec_adj[31:16];
        if (last_k) begin
          state_d = S_DECIDE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_DECIDE: begin
        wsum_d  = sum_c[19:0];
        fired_d = sum_c > 32'(thr_q);
        k_d     = '0;
        state_d = (sum_c > 32'(thr_q)) ? S_FRD : S_FIN;
      end
      S_FRD: state_d = S_FEX;
      S_FEX: begin
        if (spike) begin
          t_we    = 1'b1;
          t_wdata = (tinc > 18'sd32767) ? 16'sh7fff :
                    (tinc < -18'sd32768) ? 16'sh8000 : tinc[15:0];
        end
        if (last_k) begin
          state_d = S_FIN;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_FRD;
        end
      end
      S_LRD: state_d = S_LEX;
      S_LEX: begin
        prod_d  = 33'(rt_s) * 33'($signed({1'b0, rate_q}));
        w_d     = rw_s;
        state_d = S_LMUL;
      end
      S_LMUL: begin
        prod2_d = 48'(prod_q) * 48'(rew_q);
        state_d = S_LDS;
      end
      S_LDS: begin
        neg_d   = prod2_q < 0;
        state_d = S_LDIV;
      end
      S_LDIV: begin
        if (div_stat.done) begin
          state_d = S_LWR;
        end
      end
      S_LWR: begin
        w_we = 1'b1;
        if (nw > 35'sd32767) begin
          w_wdata = 16'sh7fff;
          sat_d   = 1'b1;
        end else if (nw < -35'sd32768) begin
          w_wdata = 16'sh8000;
          sat_d   = 1'b1;
        end else begin
          w_wdata = nw[15:0];
        end
        if (last_k) begin
          state_d = S_FIN;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_LRD;
        end
      end
      S_FIN: begin
        if (o_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ov_d = ov_q;
    if (result_o.valid && result_o.ready) begin
      ov_d = 1'b0;
    end
    if (o_load) begin
      ov_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    syn_q   <= syn_d;
    wv_q    <= wv_d;
    rew_q   <= rew_d;
    spk_q   <= spk_d;
    k_q     <= k_d;
    sum_q   <= sum_d;
    prod_q  <= prod_d;
    prod2_q <= prod2_d;
    w_q     <= w_d;
    neg_q   <= neg_d;
    fired_q <= fired_d;
    sat_q   <= sat_d;
    wsum_q  <= wsum_d;
    if (o_load) begin
      o_fired_q <= fired_q;
      o_wsum_q  <= wsum_q;
      o_sat_q   <= sat_q;
    end
  end

  assign result_o.valid     = ov_q;
  assign result_o.fired     = o_fired_q;
  assign result_o.act_sum   = o_wsum_q;
  assign result_o.saturated = o_sat_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   w_we |-> (state_q == S_CLEAR || state_q == S_LOAD || state_q == S_LWR))
    else $error("weight write outside load, learn or clear");
  assert property (@(posedge clk_i) disable iff (!rst_ni) item_acc |=> !item_i.ready)
    else $error("second beat accepted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == S_LDIV) |-> (div_stat.busy || div_stat.done))
    else $error("waiting on an idle divider");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   o_load |=> result_o.valid)
    else $error("finished result lost");
endmodule
`default_nettype wire

/* tb/sv/spiking_neuron_reward_learning_test.sv */
`default_nettype none
module spiking_neuron_reward_learning_test;
  import snrl_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    opcode_t            op;
    logic [5:0]         neuron;
    logic [3:0]         synapse;
    logic signed [15:0] weight;
    logic [15:0]        spikes;
    logic signed [15:0] reward;
  } item_t;

  typedef struct {
    logic               fired;
    logic signed [19:0] sum;
    logic               sat;
  } res_t;

  typedef struct {
    item_t it;
    bit    typed;
    res_t  res;
  } row_t;

  localparam int CELLS = 64 * 16;
  localparam opcode_t OP_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  snrl_item_if item_bus ();
  snrl_res_if  res_bus ();
  snrl_cfg_if  cfg_bus ();

  spiking_neuron_reward_learning dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_bus),
    .result_o(res_bus),
    .cfg_i   (cfg_bus)
  );

  always #5 clk = ~clk;

  // neuron state mirror
  int                 syn_weight [CELLS];
  int                 syn_trace  [CELLS];
  logic signed [19:0] thresh_q;
  logic [15:0]        discount_q;
  logic [15:0]        rate_q;

  res_t pending_results[$];
  int   errors = 0;
  bit   idle_on = 1'b1;
  int   n_items = 0, n_fired = 0, n_learn = 0, n_sat = 0;

  function automatic res_t neuron_step(item_t it);
    res_t   r;
    int     base;
    longint acc, t, num, mag, delta, nw;
    int     sg;
    r.fired = 1'b0;
    r.sum = '0;
    r.sat = 1'b0;
    base = int'(it.neuron) * 16;
    acc = 0;
    case (it.op)
      OP_LOAD: begin
        syn_weight[base + it.synapse] = it.weight;
        syn_trace[base + it.synapse] = 0;
      end
      OP_COMPUTE: begin
        for (int k = 0; k < 16; k++) begin
          t = longint'(syn_trace[base + k]) * longint'(discount_q);
          syn_trace[base + k] = int'(t / 65536);
          if (it.spikes[k]) acc += syn_weight[base + k];
        end
        if (acc > 524287) acc = 524287;
        if (acc < -524288) acc = -524288;
        r.sum = acc[19:0];
        if (acc > longint'(thresh_q)) begin
          r.fired = 1'b1;
          for (int k = 0; k < 16; k++) begin
            sg = (syn_weight[base + k] > 0) ? 1 : (syn_weight[base + k] < 0) ? -1 : 0;
            if (it.spikes[k]) begin
              t = longint'(syn_trace[base + k]) + sg * 256;
              if (t > 32767) t = 32767;
              if (t < -32768) t = -32768;
              syn_trace[base + k] = int'(t);
            end
          end
        end
      end
      OP_LEARN: begin
        for (int k = 0; k < 16; k++) begin
          mag = (syn_weight[base + k] < 0) ? -syn_weight[base + k] : syn_weight[base + k];
          if (mag == 0) mag = 1;
          num = longint'(rate_q) * longint'(syn_trace[base + k]) * longint'(it.reward);
          delta = num / (mag * 65536);
          nw = syn_weight[base + k] + delta;
          if (nw > 32767 || nw < -32768) begin
            r.sat = 1'b1;
            nw = (nw > 32767) ? 32767 : -32768;
          end
          syn_weight[base + k] = int'(nw);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(item_t it, bit typed, res_t typed_res);
    res_t r;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      item_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    item_bus.opcode        <= it.op;
    item_bus.neuron_index  <= it.neuron;
    item_bus.synapse_index <= it.synapse;
    item_bus.weight_value  <= it.weight;
    item_bus.spike_bits    <= it.spikes;
    item_bus.reward        <= it.reward;
    item_bus.valid         <= 1'b1;
    do @(posedge clk); while (!item_bus.ready);
    r = neuron_step(it);
    pending_results.push_back(typed ? typed_res : r);
    n_items++;
    if (it.op == OP_LEARN) n_learn++;
  endtask

  task automatic drain_results();
    item_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // valid stays high between back-to-back writes; the caller drops it
  task automatic cfg_write(cfg_index_t idx, logic [19:0] d);
    cfg_bus.index <= idx;
    cfg_bus.data  <= d;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_THRESHOLD: thresh_q = d;
      CFG_DISCOUNT:  discount_q = d[15:0];
      CFG_RATE:      rate_q = d[15:0];
      default: ;
    endcase
  endtask

  function automatic logic signed [15:0] pick_weight();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return 16'($signed($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic item_t make_item(opcode_t op, logic [5:0] n);
    item_t it;
    it.op = op;
    it.neuron = n;
    it.synapse = 4'($urandom);
    it.weight = pick_weight();
    case ($urandom_range(0, 5))
      0: it.spikes = 16'h0000;
      1: it.spikes = 16'hffff;
      default: it.spikes = 16'($urandom);
    endcase
    it.reward = ($urandom_range(0, 5) == 0) ? pick_weight() : 16'($urandom);
    return it;
  endfunction

  // result side: random stall bursts, checked against the oldest expectation
  int stall_left = 0;
  always @(posedge clk) begin
    res_t e;
    if (res_bus.valid && res_bus.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat fired=%0b sum=%0d sat=%0b", $time,
                 res_bus.fired, res_bus.act_sum, res_bus.saturated);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (res_bus.fired !== e.fired) begin
          $display("%0t: fired expected %0b actual %0b", $time, e.fired, res_bus.fired);
          errors++;
        end
        if (res_bus.act_sum !== e.sum) begin
          $display("%0t: act_sum expected %0d actual %0d", $time, e.sum,
                   res_bus.act_sum);
          errors++;
        end
        if (res_bus.saturated !== e.sat) begin
          $display("%0t: saturated expected %0b actual %0b", $time, e.sat,
                   res_bus.saturated);
          errors++;
        end
        if (e.fired) n_fired++;
        if (e.sat) n_sat++;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      res_bus.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  initial begin
    #40ms;
    $display("%0t: timeout", $time);
    $display("== FAIL ==");
    $finish;
  end

  function automatic row_t mk_row(opcode_t op, int n, int s, int w, int sp, int rw,
                                  bit typed, bit f, int sum);
    row_t r;
    r.it.op = op;
    r.it.neuron = 6'(n);
    r.it.synapse = 4'(s);
    r.it.weight = 16'(w);
    r.it.spikes = 16'(sp);
    r.it.reward = 16'(rw);
    r.typed = typed;
    r.res.fired = f;
    r.res.sum = 20'(sum);
    r.res.sat = 1'b0;
    return r;
  endfunction

  row_t  directed[$];
  item_t it;
  res_t  none;
  int    n;

  initial begin
    item_bus.valid = 1'b0;
    item_bus.opcode = OP_LOAD;
    item_bus.neuron_index = '0;
    item_bus.synapse_index = '0;
    item_bus.weight_value = '0;
    item_bus.spike_bits = '0;
    item_bus.reward = '0;
    res_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_THRESHOLD;
    cfg_bus.data = '0;
    for (int i = 0; i < CELLS; i++) begin
      syn_weight[i] = 0;
      syn_trace[i] = 0;
    end
    thresh_q = THRESHOLD_RST;
    discount_q = DISCOUNT_RST;
    rate_q = RATE_RST;
    none = '{1'b0, 20'sd0, 1'b0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // op, neuron, synapse, weight, spikes, reward, typed, fired, sum
    directed.push_back(mk_row(OP_COMPUTE, 0, 0, 0, 'hffff, 0, 1, 0, 0));
    directed.push_back(mk_row(OP_UNUSED, 63, 15, -1, 'hffff, -1, 1, 0, 0));
    directed.push_back(mk_row(OP_LEARN, 0, 0, 0, 0, 32767, 1, 0, 0));
    directed.push_back(mk_row(OP_LOAD, 1, 0, 32767, 0, 0, 1, 0, 0));
    directed.push_back(mk_row(OP_LOAD, 1, 1, -32768, 0, 0, 1, 0, 0));
    directed.push_back(mk_row(OP_LOAD, 1, 15, 256, 0, 0, 1, 0, 0));
    directed.push_back(mk_row(OP_LOAD, 1, 2, 0, 0, 0, 1, 0, 0));
    directed.push_back(mk_row(OP_COMPUTE, 1, 0, 0, 'h0001, 0, 1, 1, 32767));
    directed.push_back(mk_row(OP_COMPUTE, 1, 0, 0, 'h8002, 0, 1, 0, -32512));
    directed.push_back(mk_row(OP_COMPUTE, 1, 0, 0, 'h8000, 0, 1, 0, 256));
    directed.push_back(mk_row(OP_COMPUTE, 1, 0, 0, 'hffff, 0, 0, 0, 0));
    directed.push_back(mk_row(OP_COMPUTE, 1, 0, 0, 'h8005, 0, 0, 0, 0));
    directed.push_back(mk_row(OP_LEARN, 1, 0, 0, 0, 32767, 0, 0, 0));
    directed.push_back(mk_row(OP_LEARN, 1, 0, 0, 0, -32768, 0, 0, 0));
    directed.push_back(mk_row(OP_COMPUTE, 1, 0, 0, 'hffff, 0, 0, 0, 0));
    directed.push_back(mk_row(OP_LOAD, 1, 0, 1, 0, 0, 1, 0, 0));
    directed.push_back(mk_row(OP_COMPUTE, 63, 0, 0, 'hffff, 0, 1, 0, 0));
    directed.push_back(mk_row(OP_UNUSED, 0, 0, 0, 0, 0, 1, 0, 0));
    foreach (directed[i]) send_item(directed[i].it, directed[i].typed, directed[i].res);
    drain_results();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          cfg_write(CFG_THRESHOLD, 20'h80000);
          cfg_write(CFG_DISCOUNT, 20'd0);
          cfg_write(CFG_RATE, 20'hffff);
        end
        1: begin
          cfg_write(CFG_THRESHOLD, 20'h7ffff);
          cfg_write(CFG_DISCOUNT, 20'hffff);
          cfg_write(CFG_RATE, 20'd0);
        end
        2: begin
          cfg_write(CFG_THRESHOLD, 20'h80000);
          cfg_write(CFG_DISCOUNT, 20'hffff);
          cfg_write(CFG_RATE, 20'hffff);
        end
        default: begin
          cfg_write(CFG_THRESHOLD, ($urandom_range(0, 1)) ? 20'($urandom)
                                   : 20'($signed($urandom_range(0, 2048)) - 1024));
          cfg_write(CFG_DISCOUNT, 20'($urandom));
          cfg_write(CFG_RATE, 20'($urandom));
        end
      endcase
      cfg_bus.valid <= 1'b0;
      idle_on = (phase != 5) && (phase != 3 || $urandom_range(0, 1));

      if (phase == 2) begin
        // drive traces into their clip, then learn with a huge reward
        it = make_item(OP_LOAD, 6'd5);
        it.synapse = 4'd0;
        it.weight = 16'sd1;
        send_item(it, 1'b0, none);
        it.synapse = 4'd1;
        it.weight = -16'sd1;
        send_item(it, 1'b0, none);
        it = make_item(OP_COMPUTE, 6'd5);
        it.spikes = 16'h0003;
        repeat (140) send_item(it, 1'b0, none);
        it = make_item(OP_LEARN, 6'd5);
        it.reward = 16'sh7fff;
        send_item(it, 1'b0, none);
        it.reward = 16'sh8000;
        send_item(it, 1'b0, none);
      end

      n = 0;
      while (n < 260) begin
        logic [5:0] nrn;
        nrn = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, 3)) : 6'($urandom);
        if ($urandom_range(0, 3) != 0) begin
          // well-formed sequence: fill some synapses, compute a few times, sometimes learn
          repeat ($urandom_range(1, 16)) begin
            send_item(make_item(OP_LOAD, nrn), 1'b0, none);
            n++;
          end
          repeat ($urandom_range(1, 6)) begin
            send_item(make_item(OP_COMPUTE, nrn), 1'b0, none);
            n++;
          end
          if ($urandom_range(0, 2) == 0) begin
            send_item(make_item(OP_LEARN, nrn), 1'b0, none);
            n++;
          end
        end else begin
          send_item(make_item(opcode_t'($urandom_range(0, 3)), nrn), 1'b0, none);
          n++;
        end
      end
      drain_results();
    end

    repeat (700) @(posedge clk);
    $display("covered %0d items over 6 register settings: %0d fired, %0d learn, %0d clipped",
             n_items, n_fired, n_learn, n_sat);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
src/snrl_pkg.sv
src/snrl_if.sv
src/snrl_ram.sv
src/snrl_div.sv
src/spiking_neuron_reward_learning.sv
tb/sv/spiking_neuron_reward_learning_test.sv
